// ----- rtl/core/dvte_pkg.sv -----
// shared constants, command codes and job descriptor types of the routing table engine
`default_nettype none

package dvte_pkg;

  localparam int DEF_MAX_NODES  = 16;
  localparam int DEF_COST_BITS  = 16;
  localparam int LINK_BITS      = 8;
  localparam int CMD_BITS       = 2;
  localparam int NODE_COUNT_RST = 16;
  localparam int QDEPTH         = 2;

  localparam logic [CMD_BITS-1:0] CMD_INIT = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_ADV  = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_READ = 2'd2;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_INIT,
    OP_ADV,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t  op;
    logic err;
  } job_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/dvte_if.sv -----
// word channels of the routing table engine: command in, result out
`default_nettype none

interface dvte_in_if #(
  parameter int MAX_NODES = dvte_pkg::DEF_MAX_NODES
);
  import dvte_pkg::*;

  localparam int IDW = $clog2(MAX_NODES);

  logic                 valid;
  logic                 ready;
  logic [CMD_BITS-1:0]  command;
  logic [IDW-1:0]       sender_node;
  logic [IDW-1:0]       receiver_node;
  logic [IDW-1:0]       destination;
  logic [LINK_BITS-1:0] link_cost;

  modport source (
    output valid, command, sender_node, receiver_node, destination, link_cost,
    input  ready
  );

  modport sink (
    input  valid, command, sender_node, receiver_node, destination, link_cost,
    output ready
  );
endinterface

interface dvte_out_if #(
  parameter int MAX_NODES = dvte_pkg::DEF_MAX_NODES,
  parameter int COST_BITS = dvte_pkg::DEF_COST_BITS
);
  localparam int NCW = $clog2(MAX_NODES + 1);

  logic                 valid;
  logic                 ready;
  logic [COST_BITS-1:0] path_cost;
  logic [NCW-1:0]       next_hop;
  logic [NCW-1:0]       changed_count;
  logic                 error;

  modport source (
    output valid, path_cost, next_hop, changed_count, error,
    input  ready
  );

  modport sink (
    input  valid, path_cost, next_hop, changed_count, error,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/dvte_front.sv -----
// front end: node count register, command decode and id checks, two-word job queue
`default_nettype none

module dvte_front #(
  parameter int MAX_NODES = dvte_pkg::DEF_MAX_NODES
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [$clog2(MAX_NODES+1)-1:0]    cfg_wr_data,
  dvte_in_if.sink                                in_ch,
  output      logic                              job_vld,
  input  wire logic                              job_rdy,
  output      dvte_pkg::job_ctl_t                job_ctl,
  output      logic [$clog2(MAX_NODES)-1:0]      job_snd,
  output      logic [$clog2(MAX_NODES)-1:0]      job_rcv,
  output      logic [$clog2(MAX_NODES)-1:0]      job_dst,
  output      logic [dvte_pkg::LINK_BITS-1:0]    job_link,
  output      logic [$clog2(MAX_NODES+1)-1:0]    job_n
);
  import dvte_pkg::*;

  localparam int IDW    = $clog2(MAX_NODES);
  localparam int NCW    = $clog2(MAX_NODES + 1);
  localparam int QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW    = $clog2(QDEPTH + 1);
  localparam int NC_RST = (NODE_COUNT_RST > MAX_NODES) ? MAX_NODES : NODE_COUNT_RST;

  logic [NCW-1:0]       nc_r;
  logic [NCW-1:0]       act_n;
  logic [NCW-1:0]       snd_x;
  logic [NCW-1:0]       rcv_x;
  logic [NCW-1:0]       dst_x;
  job_ctl_t             cls;

  logic [QPW-1:0]       wp_r;
  logic [QPW-1:0]       rp_r;
  logic [QCW-1:0]       cnt_r;
  logic                 push;
  logic                 pop;

  job_ctl_t             q_ctl_r  [QDEPTH];
  logic [IDW-1:0]       q_snd_r  [QDEPTH];
  logic [IDW-1:0]       q_rcv_r  [QDEPTH];
  logic [IDW-1:0]       q_dst_r  [QDEPTH];
  logic [LINK_BITS-1:0] q_link_r [QDEPTH];
  logic [NCW-1:0]       q_n_r    [QDEPTH];

  // node count above the table size behaves as the table size
  assign act_n = (nc_r > NCW'(MAX_NODES)) ? NCW'(MAX_NODES) : nc_r;
  assign snd_x = NCW'(in_ch.sender_node);
  assign rcv_x = NCW'(in_ch.receiver_node);
  assign dst_x = NCW'(in_ch.destination);

  always_comb begin
    cls.op  = OP_NOP;
    cls.err = 1'b0;
    unique case (in_ch.command)
      CMD_INIT: begin
        cls.err = (snd_x >= act_n);
        cls.op  = cls.err ? OP_NOP : OP_INIT;
      end
      CMD_ADV: begin
        cls.err = (snd_x >= act_n) || (rcv_x >= act_n);
        cls.op  = cls.err ? OP_NOP : OP_ADV;
      end
      CMD_READ: begin
        cls.err = (snd_x >= act_n) || (dst_x >= act_n);
        cls.op  = cls.err ? OP_NOP : OP_READ;
      end
      default: begin
        cls.op  = OP_NOP;
        cls.err = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = (cnt_r != QCW'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign job_vld     = (cnt_r != '0);
  assign pop         = job_vld && job_rdy;

  assign job_ctl  = q_ctl_r[rp_r];
  assign job_snd  = q_snd_r[rp_r];
  assign job_rcv  = q_rcv_r[rp_r];
  assign job_dst  = q_dst_r[rp_r];
  assign job_link = q_link_r[rp_r];
  assign job_n    = q_n_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r  <= NCW'(NC_RST);
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        nc_r <= cfg_wr_data;
      end
      if (push) begin
        wp_r <= (wp_r == QPW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == QPW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_ctl_r[wp_r]  <= cls;
      q_snd_r[wp_r]  <= in_ch.sender_node;
      q_rcv_r[wp_r]  <= in_ch.receiver_node;
      q_dst_r[wp_r]  <= in_ch.destination;
      q_link_r[wp_r] <= in_ch.link_cost;
      q_n_r[wp_r]    <= act_n;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(QDEPTH))
    else $error("job queue count beyond depth");

  a_cnt_push: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("job queue lost a word");

  a_adv_ids: assert property (@(posedge clk) disable iff (!rst_n)
    job_vld && (job_ctl.op == OP_ADV) |-> (NCW'(job_rcv) < job_n) && (NCW'(job_snd) < job_n))
    else $error("advertise queued with a node id out of range");

endmodule

`default_nettype wire

// ----- rtl/core/dvte_back.sv -----
// back end: table memory, row walk sequencer for init, advertise and read, result register
`default_nettype none

module dvte_back #(
  parameter int MAX_NODES = dvte_pkg::DEF_MAX_NODES,
  parameter int COST_BITS = dvte_pkg::DEF_COST_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              job_vld,
  output      logic                              job_rdy,
  input  wire dvte_pkg::job_ctl_t                job_ctl,
  input  wire logic [$clog2(MAX_NODES)-1:0]      job_snd,
  input  wire logic [$clog2(MAX_NODES)-1:0]      job_rcv,
  input  wire logic [$clog2(MAX_NODES)-1:0]      job_dst,
  input  wire logic [dvte_pkg::LINK_BITS-1:0]    job_link,
  input  wire logic [$clog2(MAX_NODES+1)-1:0]    job_n,
  dvte_out_if.source                             out_ch
);
  import dvte_pkg::*;

  localparam int IDW   = $clog2(MAX_NODES);
  localparam int NCW   = $clog2(MAX_NODES + 1);
  localparam int HW    = NCW;
  localparam int DEPTH = MAX_NODES * MAX_NODES;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = COST_BITS + HW;

  localparam logic [COST_BITS-1:0] UNREACH  = {COST_BITS{1'b1}};
  localparam logic [HW-1:0]        HOP_NONE = HW'(MAX_NODES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  function automatic logic [AW-1:0] slot(input logic [IDW-1:0] row, input logic [IDW-1:0] col);
    slot = AW'(row) * AW'(MAX_NODES) + AW'(col);
  endfunction

  // control
  logic [1:0]           state_r;
  logic                 rd_go_r;
  logic                 p_vld_r;
  logic                 ov_r;
  logic [MAX_NODES-1:0] row_vld_r;

  // job context
  op_t                  op_r;
  logic                 err_r;
  logic [IDW-1:0]       snd_r;
  logic [IDW-1:0]       rcv_r;
  logic [LINK_BITS-1:0] link_r;
  logic [NCW-1:0]       n_r;
  logic                 sv_r;
  logic                 rv_r;
  logic [IDW-1:0]       rd_j_r;
  logic [IDW-1:0]       last_r;
  logic [IDW-1:0]       p_j_r;
  logic [NCW-1:0]       chg_r;
  logic [COST_BITS-1:0] res_cost_r;
  logic [HW-1:0]        res_hop_r;

  // result register
  logic [COST_BITS-1:0] o_cost_r;
  logic [HW-1:0]        o_hop_r;
  logic [NCW-1:0]       o_chg_r;
  logic                 o_err_r;

  // table memory, each word is {cost, next hop}
  logic [EW-1:0]        mem [DEPTH];
  logic [EW-1:0]        rd_a_r;
  logic [EW-1:0]        rd_b_r;
  logic [AW-1:0]        raddr_a;
  logic [AW-1:0]        raddr_b;
  logic [AW-1:0]        waddr;
  logic [EW-1:0]        wdata;
  logic                 mem_we;

  logic                 take;
  logic                 out_load;
  logic [COST_BITS-1:0] a_cost;
  logic [HW-1:0]        a_hop;
  logic [COST_BITS-1:0] b_cost;
  logic [HW-1:0]        b_hop;
  logic [COST_BITS:0]   sum;
  logic [COST_BITS-1:0] sat;
  logic                 in_rng;
  logic                 better;
  logic [HW-1:0]        snd_hop;
  logic [EW-1:0]        init_word;

  assign job_rdy  = (state_r == S_IDLE);
  assign take     = job_vld && job_rdy;
  assign out_load = (state_r == S_DONE) && (!ov_r || out_ch.ready);

  // rows never written read as unreachable with no next hop
  assign a_cost = sv_r ? rd_a_r[EW-1 -: COST_BITS] : UNREACH;
  assign a_hop  = sv_r ? rd_a_r[HW-1:0]            : HOP_NONE;
  assign b_cost = rv_r ? rd_b_r[EW-1 -: COST_BITS] : UNREACH;
  assign b_hop  = rv_r ? rd_b_r[HW-1:0]            : HOP_NONE;

  // saturating relaxation
  assign sum     = {1'b0, a_cost} + (COST_BITS + 1)'(link_r);
  assign sat     = sum[COST_BITS] ? UNREACH : sum[COST_BITS-1:0];
  assign in_rng  = (NCW'(p_j_r) < n_r);
  assign better  = (op_r == OP_ADV) && in_rng && (sat < b_cost);
  assign snd_hop = HW'(snd_r);

  assign init_word = (p_j_r == snd_r) ? {{COST_BITS{1'b0}}, snd_hop} : {UNREACH, HOP_NONE};

  assign raddr_a = slot(snd_r, rd_j_r);
  assign raddr_b = slot(rcv_r, rd_j_r);
  assign waddr   = slot((op_r == OP_INIT) ? snd_r : rcv_r, p_j_r);
  // a row first touched by an advertise is filled out to its full width
  assign mem_we  = (state_r == S_WALK) && p_vld_r &&
                   ((op_r == OP_INIT) || ((op_r == OP_ADV) && (better || !rv_r)));
  assign wdata   = (op_r == OP_INIT) ? init_word :
                   (better ? {sat, snd_hop} : {b_cost, b_hop});

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[raddr_a];
    rd_b_r <= mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_go_r   <= 1'b0;
      p_vld_r   <= 1'b0;
      ov_r      <= 1'b0;
      row_vld_r <= '0;
    end else begin
      if (out_load) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (job_vld) begin
            if (job_ctl.op == OP_NOP) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_WALK;
              rd_go_r <= 1'b1;
            end
            if (job_ctl.op == OP_INIT) begin
              row_vld_r[job_snd] <= 1'b1;
            end
            if (job_ctl.op == OP_ADV) begin
              row_vld_r[job_rcv] <= 1'b1;
            end
          end
        end
        S_WALK: begin
          p_vld_r <= rd_go_r;
          if (rd_go_r && (rd_j_r == last_r)) begin
            rd_go_r <= 1'b0;
          end
          if (p_vld_r && !rd_go_r) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (job_vld) begin
          op_r       <= job_ctl.op;
          err_r      <= job_ctl.err;
          snd_r      <= job_snd;
          rcv_r      <= job_rcv;
          link_r     <= job_link;
          n_r        <= job_n;
          sv_r       <= row_vld_r[job_snd];
          rv_r       <= row_vld_r[job_rcv];
          rd_j_r     <= (job_ctl.op == OP_READ) ? job_dst : '0;
          chg_r      <= '0;
          res_cost_r <= '0;
          res_hop_r  <= HOP_NONE;
          if (job_ctl.op == OP_READ) begin
            last_r <= job_dst;
          end else if ((job_ctl.op == OP_ADV) && row_vld_r[job_rcv]) begin
            last_r <= IDW'(job_n - 1'b1);
          end else begin
            last_r <= IDW'(MAX_NODES - 1);
          end
        end
      end
      S_WALK: begin
        p_j_r <= rd_j_r;
        if (rd_go_r && (rd_j_r != last_r)) begin
          rd_j_r <= rd_j_r + 1'b1;
        end
        if (p_vld_r) begin
          chg_r <= chg_r + NCW'(better);
          if (op_r == OP_READ) begin
            res_cost_r <= a_cost;
            res_hop_r  <= a_hop;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          o_cost_r <= res_cost_r;
          o_hop_r  <= res_hop_r;
          o_chg_r  <= chg_r;
          o_err_r  <= err_r;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.path_cost     = o_cost_r;
  assign out_ch.next_hop      = o_hop_r;
  assign out_ch.changed_count = o_chg_r;
  assign out_ch.error         = o_err_r;

  a_pipe_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r |-> state_r == S_WALK)
    else $error("walk stage live outside a walk");

  a_write_ops: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (op_r == OP_INIT) || (op_r == OP_ADV))
    else $error("table written by a command that does not write");

  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.error |-> (out_ch.changed_count == '0) &&
                                     (out_ch.next_hop == HOP_NONE) &&
                                     (out_ch.path_cost == '0))
    else $error("error word carries data");

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> state_r != S_IDLE)
    else $error("job taken but sequencer stayed idle");

endmodule

`default_nettype wire

// ----- rtl/core/distance_vector_table_engine.sv -----
// top level of the distance-vector routing table engine
`default_nettype none

// Keeps a MAX_NODES x MAX_NODES table of path costs and next hops and runs
// init, advertise (Bellman-Ford relaxation with a saturating add) and read
// commands, one result word per command word. The front end checks node ids
// against node_count and queues up to two decoded commands, so words are
// accepted while the back end works. The back end owns a table memory with
// one write port and two registered read ports and walks one entry a cycle:
// an advertise walks node_count entries (MAX_NODES the first time a row is
// written by an advertise rather than an init), an init MAX_NODES, a read
// one, and a command refused for a bad id or an unused code none. Rows not
// yet written are tracked by one valid bit each, so no clearing pass is run
// after reset. node_count is written through cfg_wr_en/cfg_wr_data and must
// only change while the block is idle.
module distance_vector_table_engine
  import dvte_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int COST_BITS = DEF_COST_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [$clog2(MAX_NODES+1)-1:0] cfg_wr_data,
  dvte_in_if.sink                             in_ch,
  dvte_out_if.source                          out_ch
);

  localparam int IDW = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);

  logic                 job_vld;
  logic                 job_rdy;
  job_ctl_t             job_ctl;
  logic [IDW-1:0]       job_snd;
  logic [IDW-1:0]       job_rcv;
  logic [IDW-1:0]       job_dst;
  logic [LINK_BITS-1:0] job_link;
  logic [NCW-1:0]       job_n;

  dvte_front #(
    .MAX_NODES (MAX_NODES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .job_vld     (job_vld),
    .job_rdy     (job_rdy),
    .job_ctl     (job_ctl),
    .job_snd     (job_snd),
    .job_rcv     (job_rcv),
    .job_dst     (job_dst),
    .job_link    (job_link),
    .job_n       (job_n)
  );

  dvte_back #(
    .MAX_NODES (MAX_NODES),
    .COST_BITS (COST_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_vld  (job_vld),
    .job_rdy  (job_rdy),
    .job_ctl  (job_ctl),
    .job_snd  (job_snd),
    .job_rcv  (job_rcv),
    .job_dst  (job_dst),
    .job_link (job_link),
    .job_n    (job_n),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_distance_vector_table_engine.sv -----
// testbench of the routing table engine: command words checked against a shadow of its tables
module tb_distance_vector_table_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import dvte_pkg::*;

  localparam int NODES         = DEF_MAX_NODES;
  localparam int COST_W        = DEF_COST_BITS;
  localparam int NODE_W        = $clog2(NODES);
  localparam int HOP_W         = $clog2(NODES + 1);
  localparam logic [COST_W-1:0]   UNREACH    = '1;
  localparam logic [HOP_W-1:0]    HOP_NONE   = HOP_W'(NODES);
  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [CMD_BITS-1:0]  command;
    logic [NODE_W-1:0]    sender_node;
    logic [NODE_W-1:0]    receiver_node;
    logic [NODE_W-1:0]    destination;
    logic [LINK_BITS-1:0] link_cost;
  } cmd_word_t;

  typedef struct packed {
    logic [COST_W-1:0] path_cost;
    logic [HOP_W-1:0]  next_hop;
    logic [HOP_W-1:0]  changed_count;
    logic              error;
  } result_word_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [HOP_W-1:0] cfg_wr_data;

  dvte_in_if  in_ch ();
  dvte_out_if out_ch ();

  distance_vector_table_engine u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always #1 clk = ~clk;

  // shadow of the routing tables and of node_count
  logic [COST_W-1:0] shadow_cost [NODES][NODES];
  logic [HOP_W-1:0]  shadow_hop  [NODES][NODES];
  logic [HOP_W-1:0]  shadow_nodes;

  cmd_word_t    pending_words [$];
  result_word_t results_due [$];

  int unsigned cycle_count = 0;
  int          fail_count  = 0;
  bit          sender_calm   = 1'b0;
  bit          receiver_calm = 1'b0;
  bit          hold_go  = 1'b0;
  logic        hold_off = 1'b0;

  bit drv_fire;
  bit drv_next;
  bit drv_gap_set;
  int drv_gap;
  int mon_stall;

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    fail_count++;
  endtask

  // runs one command word through the shadow tables and queues its result
  function automatic void apply_command(input cmd_word_t w);
    int n;
    int snd;
    int rcv;
    int dst;
    logic [COST_W:0] sum;
    result_word_t r;
    n   = (shadow_nodes > NODES) ? NODES : int'(shadow_nodes);
    snd = int'(w.sender_node);
    rcv = int'(w.receiver_node);
    dst = int'(w.destination);
    r.path_cost     = '0;
    r.next_hop      = HOP_NONE;
    r.changed_count = '0;
    r.error         = 1'b0;
    case (w.command)
      CMD_INIT: begin
        if (snd >= n) begin
          r.error = 1'b1;
        end else begin
          // the whole row is rewritten, also beyond node_count
          for (int j = 0; j < NODES; j++) begin
            shadow_cost[snd][j] = (j == snd) ? '0 : UNREACH;
            shadow_hop[snd][j]  = (j == snd) ? HOP_W'(snd) : HOP_NONE;
          end
        end
      end
      CMD_ADV: begin
        if (snd >= n || rcv >= n) begin
          r.error = 1'b1;
        end else begin
          for (int j = 0; j < n; j++) begin
            sum = {1'b0, shadow_cost[snd][j]} + (COST_W + 1)'(w.link_cost);
            if (sum > UNREACH) sum = {1'b0, UNREACH};
            if (sum < shadow_cost[rcv][j]) begin
              shadow_cost[rcv][j] = sum[COST_W-1:0];
              shadow_hop[rcv][j]  = HOP_W'(snd);
              r.changed_count++;
            end
          end
        end
      end
      CMD_READ: begin
        if (snd >= n || dst >= n) begin
          r.error = 1'b1;
        end else begin
          r.path_cost = shadow_cost[snd][dst];
          r.next_hop  = shadow_hop[snd][dst];
        end
      end
      default: ;
    endcase
    results_due.insert(results_due.size(), r);
  endfunction

  task automatic check_result();
    result_word_t due;
    if (results_due.size() == 0) begin
      report_mismatch($sformatf("result word with nothing due, cost %0d hop %0d",
                                out_ch.path_cost, out_ch.next_hop));
      return;
    end
    due = results_due.pop_front();
    if (out_ch.path_cost !== due.path_cost)
      report_mismatch($sformatf("path_cost %0d, wanted %0d", out_ch.path_cost, due.path_cost));
    if (out_ch.next_hop !== due.next_hop)
      report_mismatch($sformatf("next_hop %0d, wanted %0d", out_ch.next_hop, due.next_hop));
    if (out_ch.changed_count !== due.changed_count)
      report_mismatch($sformatf("changed_count %0d, wanted %0d",
                                out_ch.changed_count, due.changed_count));
    if (out_ch.error !== due.error)
      report_mismatch($sformatf("error %0b, wanted %0b", out_ch.error, due.error));
  endtask

  // sender: holds each word until taken, then waits a drawn gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      drv_gap_set = 1'b0;
    end else begin
      drv_fire = in_ch.valid && in_ch.ready;
      if (drv_fire) apply_command(pending_words.pop_front());
      drv_next = in_ch.valid && !drv_fire;
      if (!drv_next && pending_words.size() != 0) begin
        if (!drv_gap_set) begin
          drv_gap     = sender_calm ? 0 : $urandom_range(0, 15);
          drv_gap_set = 1'b1;
        end
        if (drv_gap == 0) begin
          drv_next    = 1'b1;
          drv_gap_set = 1'b0;
          in_ch.command       <= pending_words[0].command;
          in_ch.sender_node   <= pending_words[0].sender_node;
          in_ch.receiver_node <= pending_words[0].receiver_node;
          in_ch.destination   <= pending_words[0].destination;
          in_ch.link_cost     <= pending_words[0].link_cost;
        end else begin
          drv_gap--;
        end
      end
      in_ch.valid <= drv_next;
    end
  end

  // receiver: checks each word taken, then stalls for a drawn count
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      mon_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_result();
        mon_stall = receiver_calm ? 0 : $urandom_range(0, 15);
      end
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else if (mon_stall != 0) begin
        mon_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // long hold-off on the result side so the command queue fills and stalls
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void queue_word(input logic [CMD_BITS-1:0] cmd, input int s, input int r,
                                     input int d, input int l);
    cmd_word_t w;
    w.command       = cmd;
    w.sender_node   = NODE_W'(s);
    w.receiver_node = NODE_W'(r);
    w.destination   = NODE_W'(d);
    w.link_cost     = LINK_BITS'(l);
    pending_words.insert(pending_words.size(), w);
  endfunction

  function automatic cmd_word_t random_word();
    cmd_word_t w;
    w.command       = CMD_BITS'($urandom_range(0, 3));
    w.sender_node   = NODE_W'($urandom_range(0, NODES - 1));
    w.receiver_node = NODE_W'($urandom_range(0, NODES - 1));
    w.destination   = NODE_W'($urandom_range(0, NODES - 1));
    w.link_cost     = LINK_BITS'($urandom_range(0, 255));
    return w;
  endfunction

  // mostly a node in use, now and then any id
  function automatic logic [NODE_W-1:0] pick_node(input int n_eff);
    if (n_eff == 0 || $urandom_range(0, 9) == 0) return NODE_W'($urandom_range(0, NODES - 1));
    return NODE_W'($urandom_range(0, n_eff - 1));
  endfunction

  task automatic wait_idle();
    while (pending_words.size() != 0 || results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_node_count(input int value);
    wait_idle();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= HOP_W'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_nodes = HOP_W'(value);
  endtask

  task automatic random_phase(input int value, input int count, input bit calm);
    int n_eff;
    int pick;
    cmd_word_t w;
    set_node_count(value);
    sender_calm   = calm;
    receiver_calm = calm ? 1'b0 : ($urandom_range(0, 3) == 0);
    n_eff = (value > NODES) ? NODES : value;
    // bring a few rows up before relaxing them
    for (int k = 0; k < n_eff && k < 4; k++)
      queue_word(CMD_INIT, $urandom_range(0, n_eff - 1), $urandom_range(0, NODES - 1),
                 $urandom_range(0, NODES - 1), $urandom_range(0, 255));
    for (int k = 0; k < count; k++) begin
      w    = random_word();
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        w.command     = CMD_INIT;
        w.sender_node = pick_node(n_eff);
      end else if (pick < 55) begin
        w.command       = CMD_ADV;
        w.sender_node   = pick_node(n_eff);
        w.receiver_node = pick_node(n_eff);
      end else if (pick < 90) begin
        w.command     = CMD_READ;
        w.sender_node = pick_node(n_eff);
        w.destination = pick_node(n_eff);
      end else if (pick < 95) begin
        w.command = CMD_UNUSED;
      end
      pending_words.insert(pending_words.size(), w);
    end
  endtask

  // bounces one route between two rows, re-initialising the receiving row
  // each time, until the cost saturates at unreachable
  task automatic pump_to_saturation();
    int cur;
    int oth;
    int tmp;
    set_node_count(NODES);
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    queue_word(CMD_INIT, 0, 0, 0, 0);
    queue_word(CMD_INIT, 1, 0, 0, 0);
    queue_word(CMD_ADV, 0, 1, 0, 255);
    cur = 1;
    oth = 2;
    for (int k = 2; k <= 258; k++) begin
      queue_word(CMD_INIT, oth, $urandom_range(0, NODES - 1), 0, 0);
      // one short of unreachable, then a sum past it
      queue_word(CMD_ADV, cur, oth, 0, (k == 257) ? 254 : 255);
      if (k % 32 == 0 || k >= 256) queue_word(CMD_READ, oth, 0, 0, 0);
      tmp = cur;
      cur = oth;
      oth = tmp;
    end
    queue_word(CMD_READ, cur, 0, 0, 0);
    queue_word(CMD_READ, oth, 0, 0, 0);
  endtask

  initial begin
    int phase_counts [10];
    phase_counts = '{31, 0, 1, 2, 5, 17, 9, 3, 16, 12};
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_ch.valid         = 1'b0;
    in_ch.command       = CMD_INIT;
    in_ch.sender_node   = '0;
    in_ch.receiver_node = '0;
    in_ch.destination   = '0;
    in_ch.link_cost     = '0;
    out_ch.ready        = 1'b0;
    for (int i = 0; i < NODES; i++)
      for (int j = 0; j < NODES; j++) begin
        shadow_cost[i][j] = UNREACH;
        shadow_hop[i][j]  = HOP_NONE;
      end
    shadow_nodes = HOP_W'(NODE_COUNT_RST);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed words at the reset node_count
    queue_word(CMD_READ, 0, 0, 0, 0);
    queue_word(CMD_READ, 15, 0, 15, 0);
    queue_word(CMD_UNUSED, 15, 15, 15, 255);
    queue_word(CMD_INIT, 0, 0, 0, 0);
    queue_word(CMD_INIT, 15, 0, 0, 0);
    queue_word(CMD_READ, 0, 0, 0, 0);
    queue_word(CMD_READ, 0, 0, 15, 0);
    queue_word(CMD_READ, 15, 0, 15, 0);
    queue_word(CMD_ADV, 0, 15, 0, 0);
    queue_word(CMD_ADV, 15, 0, 0, 255);
    queue_word(CMD_READ, 15, 0, 0, 0);
    queue_word(CMD_READ, 0, 0, 15, 0);
    queue_word(CMD_ADV, 0, 15, 0, 255);
    queue_word(CMD_ADV, 0, 0, 0, 0);
    queue_word(CMD_INIT, 7, 0, 0, 0);
    queue_word(CMD_ADV, 7, 0, 0, 1);
    queue_word(CMD_ADV, 0, 7, 0, 254);
    queue_word(CMD_READ, 7, 0, 15, 0);
    queue_word(CMD_READ, 0, 0, 7, 0);

    // shrunk table: ids past the end are refused, the tables stay
    set_node_count(3);
    queue_word(CMD_INIT, 3, 0, 0, 0);
    queue_word(CMD_ADV, 0, 5, 0, 10);
    queue_word(CMD_ADV, 5, 0, 0, 10);
    queue_word(CMD_READ, 2, 0, 9, 0);
    queue_word(CMD_READ, 9, 0, 0, 0);
    queue_word(CMD_READ, 2, 0, 2, 0);
    set_node_count(0);
    queue_word(CMD_INIT, 0, 0, 0, 0);
    queue_word(CMD_READ, 0, 0, 0, 0);
    // oversized count acts as the full table
    set_node_count(31);
    queue_word(CMD_READ, 15, 0, 15, 0);
    queue_word(CMD_ADV, 15, 7, 0, 3);

    foreach (phase_counts[p])
      random_phase(phase_counts[p], 4, ($urandom_range(0, 3) == 0));

    random_phase(NODES, 8, 1'b1);
    hold_go = 1'b1;

    pump_to_saturation();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (results_due.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", results_due.size()));
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/dvte_pkg.sv
rtl/core/dvte_if.sv
rtl/core/dvte_front.sv
rtl/core/dvte_back.sv
rtl/core/distance_vector_table_engine.sv
tb/sv/tb_distance_vector_table_engine.sv
